### rtl/object_record_stream_parser_unit_assert.svh
// ---------------------------------------------------------------------------
// assertion macros for the object record stream parser
// concurrent checks, clocked on clk, disabled in reset
// ---------------------------------------------------------------------------
`ifndef OBJECT_RECORD_STREAM_PARSER_UNIT_ASSERT_SVH
`define OBJECT_RECORD_STREAM_PARSER_UNIT_ASSERT_SVH

// same-cycle implication
`define ORSP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("orsp check failed");

// next-cycle implication
`define ORSP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("orsp check failed");

`endif

### rtl/orsp_pkg.sv
// ---------------------------------------------------------------------------
// orsp_pkg
// shared types, constants and character helpers of the record parser
// ---------------------------------------------------------------------------
package orsp_pkg;

  localparam int MAX_LINE       = 1023;
  localparam int MAX_TEXT_BYTES = 31;
  localparam int COL_W          = 10;
  localparam int FIFO_DEPTH     = 4;
  localparam int FIFO_AW        = 2;
  localparam int FIFO_CW        = 3;

  typedef enum logic [2:0] {
    K_NONE = 3'd0, K_H = 3'd1, K_T = 3'd2, K_D = 3'd3,
    K_R = 3'd4, K_M = 3'd5, K_E = 3'd6
  } rec_kind_t;

  typedef enum logic [3:0] {
    F_PROG_NAME = 4'd0, F_START = 4'd1, F_SIZE = 4'd2, F_TEXT_ADDR = 4'd3,
    F_TEXT_LEN = 4'd4, F_TEXT_BYTE = 4'd5, F_EXPORT = 4'd6, F_IMPORT = 4'd7,
    F_MOD_ADDR = 4'd8, F_NIBBLES = 4'd9, F_MOD_SYMBOL = 4'd10, F_ENTRY = 4'd11,
    F_REC_END = 4'd12, F_LOAD_STATUS = 4'd13
  } field_t;

  localparam logic       KIND_CHAR = 1'b0;
  localparam logic       KIND_EOF  = 1'b1;
  localparam logic [7:0] CH_NL     = 8'd10;

  typedef struct packed {
    logic        valid;
    field_t      field;
    logic [23:0] value;
    logic [47:0] symbol;
    logic        plus_sign;
    logic        status;
    logic        last;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] digit;
  } hex_t;

  function automatic hex_t hex_digit(input logic [7:0] c);
    hex_t h;
    h.ok = 1'b1;
    h.digit = 4'd0;
    if (c >= "0" && c <= "9") h.digit = 4'(c - "0");
    else if (c >= "A" && c <= "F") h.digit = 4'(c - "A" + 8'd10);
    else if (c >= "a" && c <= "f") h.digit = 4'(c - "a" + 8'd10);
    else h.ok = 1'b0;
    return h;
  endfunction

  function automatic logic name_char_ok(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
           (c >= "a" && c <= "z") || c == " " || c == "-" ||
           c == "_" || c == "+";
  endfunction

endpackage

### rtl/orsp_if.sv
// ---------------------------------------------------------------------------
// orsp channel interfaces
// input character channel and decoded result channel
// ---------------------------------------------------------------------------
interface orsp_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] char_code;
  modport source (output valid, kind, char_code, input ready);
  modport sink   (input valid, kind, char_code, output ready);
endinterface

interface orsp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  field;
  logic [23:0] value;
  logic [47:0] symbol;
  logic        plus_sign;
  logic        status;
  logic        last;
  modport source (output valid, field, value, symbol, plus_sign, status, last,
                  input ready);
  modport sink   (input valid, field, value, symbol, plus_sign, status, last,
                  output ready);
endinterface

### rtl/orsp_core.sv
// ---------------------------------------------------------------------------
// orsp_core
// parser state and one-step decode of a registered input request
// ---------------------------------------------------------------------------
module orsp_core import orsp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic       kind,
  input  logic [7:0] char_code,
  output result_t    res_a,
  output result_t    res_b
);

  logic [COL_W-1:0] column, column_next;
  rec_kind_t        rkind, rkind_next;
  logic [23:0]      hacc, hacc_next;
  logic [47:0]      nshift, nshift_next;
  logic             nnb, nnb_next;
  logic [7:0]       tlen, tlen_next;
  logic             sign, sign_next;
  logic             first_line, first_line_next;
  logic             hdr, hdr_next;
  logic             ends, ends_next;
  logic             failed, failed_next;
  logic [3:0]       grp, grp_next;   // (column-1) mod 12 of the next char

  always_comb begin
    hex_t             h;
    logic [23:0]      hv;
    logic [47:0]      ns;
    logic             nb;
    logic             nm_ok;
    logic             viol;
    logic             le;
    logic             ok;
    logic [2:0]       g6;
    logic [COL_W-1:0] p;
    logic [COL_W-1:0] tend;
    result_t          r;

    column_next = column;   rkind_next = rkind;   hacc_next = hacc;
    nshift_next = nshift;   nnb_next = nnb;       tlen_next = tlen;
    sign_next = sign;       first_line_next = first_line;
    hdr_next = hdr;         ends_next = ends;     failed_next = failed;
    grp_next = grp;
    res_a = '0;
    res_b = '0;
    r = '0;
    viol = 1'b0;
    ok = 1'b0;

    h = hex_digit(char_code);
    hv = {hacc[19:0], h.digit};
    ns = {nshift[39:0], char_code};
    nb = nnb | (char_code != " ");
    nm_ok = name_char_ok(char_code);
    g6 = (grp >= 4'd6) ? 3'(grp - 4'd6) : grp[2:0];
    p = column;
    tend = COL_W'({tlen, 1'b0}) + COL_W'(9);

    le = step && !failed &&
         ((kind == KIND_CHAR && char_code == CH_NL) ||
          (kind == KIND_EOF && column != '0));

    if (le) begin
      unique case (rkind)
        K_H:     ok = (column == COL_W'(19));
        K_T:     ok = (column == tend);
        K_D:     ok = (grp == 4'd0);
        K_R:     ok = (g6 == 3'd0);
        K_M:     ok = (column == COL_W'(9)) || (column == COL_W'(16));
        K_E:     ok = (column == COL_W'(7));
        default: ok = 1'b0;
      endcase
      if (!ok) begin
        viol = 1'b1;
      end else begin
        r.valid = 1'b1;
        r.field = F_REC_END;
        if (rkind == K_H) hdr_next = 1'b1;
        if (rkind == K_E) ends_next = 1'b1;
        first_line_next = 1'b0;
      end
      column_next = '0; rkind_next = K_NONE; tlen_next = '0; sign_next = 1'b0;
      hacc_next = '0; nshift_next = '0; nnb_next = 1'b0; grp_next = '0;
    end else if (step && kind == KIND_CHAR && !failed) begin
      if (column >= COL_W'(MAX_LINE)) begin
        viol = 1'b1;
      end else if (column == '0) begin
        tlen_next = '0; sign_next = 1'b0; grp_next = '0;
        hacc_next = '0; nshift_next = '0; nnb_next = 1'b0;
        if (ends) viol = 1'b1;
        else if (char_code == "H") begin
          if (!first_line) viol = 1'b1; else rkind_next = K_H;
        end else if (first_line) viol = 1'b1;
        else if (char_code == "T") rkind_next = K_T;
        else if (char_code == "D") rkind_next = K_D;
        else if (char_code == "R") rkind_next = K_R;
        else if (char_code == "M") rkind_next = K_M;
        else if (char_code == "E") rkind_next = K_E;
        else viol = 1'b1;
      end else begin
        grp_next = (grp == 4'd11) ? 4'd0 : grp + 4'd1;
        unique case (rkind)
          K_H: begin
            if (p <= COL_W'(6)) begin
              if (!nm_ok) viol = 1'b1;
              else begin
                nshift_next = ns; nnb_next = nb;
                if (p == COL_W'(6)) begin
                  if (!nb) viol = 1'b1;
                  else begin
                    r.valid = 1'b1; r.field = F_PROG_NAME; r.symbol = ns;
                    hacc_next = '0; nshift_next = '0; nnb_next = 1'b0;
                  end
                end
              end
            end else if (p <= COL_W'(18)) begin
              if (!h.ok) viol = 1'b1;
              else begin
                hacc_next = hv;
                if (p == COL_W'(12) || p == COL_W'(18)) begin
                  r.valid = 1'b1; r.value = hv;
                  r.field = (p == COL_W'(12)) ? F_START : F_SIZE;
                  hacc_next = '0;
                end
              end
            end else viol = 1'b1;
          end
          K_T: begin
            if (p <= COL_W'(8)) begin
              if (!h.ok) viol = 1'b1;
              else begin
                hacc_next = hv;
                if (p == COL_W'(6)) begin
                  r.valid = 1'b1; r.field = F_TEXT_ADDR; r.value = hv;
                  hacc_next = '0;
                end else if (p == COL_W'(8)) begin
                  if (hv > 24'(MAX_TEXT_BYTES)) viol = 1'b1;
                  else begin
                    tlen_next = hv[7:0];
                    r.valid = 1'b1; r.field = F_TEXT_LEN; r.value = hv;
                    hacc_next = '0;
                  end
                end
              end
            end else if (p >= tend) viol = 1'b1;
            else if (!h.ok) viol = 1'b1;
            else begin
              hacc_next = hv;
              if (!p[0]) begin   // second digit of a byte sits at an even column
                r.valid = 1'b1; r.field = F_TEXT_BYTE; r.value = hv;
                hacc_next = '0;
              end
            end
          end
          K_D: begin
            if (grp < 4'd6) begin
              if (!nm_ok) viol = 1'b1;
              else begin
                nshift_next = ns; nnb_next = nb;
                if (grp == 4'd5 && !nb) viol = 1'b1;
              end
            end else if (!h.ok) viol = 1'b1;
            else begin
              hacc_next = hv;
              if (grp == 4'd11) begin
                r.valid = 1'b1; r.field = F_EXPORT; r.value = hv; r.symbol = nshift;
                hacc_next = '0; nshift_next = '0; nnb_next = 1'b0;
              end
            end
          end
          K_R: begin
            if (!nm_ok) viol = 1'b1;
            else begin
              nshift_next = ns; nnb_next = nb;
              if (g6 == 3'd5) begin
                if (!nb) viol = 1'b1;
                else begin
                  r.valid = 1'b1; r.field = F_IMPORT; r.symbol = ns;
                  hacc_next = '0; nshift_next = '0; nnb_next = 1'b0;
                end
              end
            end
          end
          K_M: begin
            if (p <= COL_W'(8)) begin
              if (!h.ok) viol = 1'b1;
              else begin
                hacc_next = hv;
                if (p == COL_W'(6) || p == COL_W'(8)) begin
                  r.valid = 1'b1; r.value = hv;
                  r.field = (p == COL_W'(6)) ? F_MOD_ADDR : F_NIBBLES;
                  hacc_next = '0;
                end
              end
            end else if (p == COL_W'(9)) begin
              if (char_code == "+") sign_next = 1'b1;
              else if (char_code == "-") sign_next = 1'b0;
              else viol = 1'b1;
            end else if (p <= COL_W'(15)) begin
              if (!nm_ok) viol = 1'b1;
              else begin
                nshift_next = ns; nnb_next = nb;
                if (p == COL_W'(15)) begin
                  if (!nb) viol = 1'b1;
                  else begin
                    r.valid = 1'b1; r.field = F_MOD_SYMBOL; r.symbol = ns;
                    r.plus_sign = sign;
                    hacc_next = '0; nshift_next = '0; nnb_next = 1'b0;
                  end
                end
              end
            end else viol = 1'b1;
          end
          K_E: begin
            if (p <= COL_W'(6)) begin
              if (!h.ok) viol = 1'b1;
              else begin
                hacc_next = hv;
                if (p == COL_W'(6)) begin
                  r.valid = 1'b1; r.field = F_ENTRY; r.value = hv;
                  hacc_next = '0;
                end
              end
            end else viol = 1'b1;
          end
          default: viol = 1'b1;
        endcase
      end
      if (!viol) column_next = column + COL_W'(1);
    end

    if (viol) begin
      failed_next = 1'b1;
      r = '0;
      r.valid = 1'b1;
      r.field = F_LOAD_STATUS;
      r.status = 1'b1;
    end

    if (step && kind == KIND_EOF) begin
      res_a = r;
      res_b = '0;
      res_b.field = F_LOAD_STATUS;
      res_b.status = failed_next || !hdr_next || !ends_next;
      res_b.last = 1'b1;
      res_b.valid = 1'b1;
      if (!r.valid) begin
        res_a = res_b;
        res_b = '0;
      end
      column_next = '0; rkind_next = K_NONE; hacc_next = '0; nshift_next = '0;
      nnb_next = 1'b0; tlen_next = '0; sign_next = 1'b0; first_line_next = 1'b1;
      hdr_next = 1'b0; ends_next = 1'b0; failed_next = 1'b0; grp_next = '0;
    end else begin
      res_a = r;
      res_a.last = r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column <= '0; rkind <= K_NONE; hacc <= '0; nshift <= '0; nnb <= 1'b0;
      tlen <= '0; sign <= 1'b0; first_line <= 1'b1; hdr <= 1'b0;
      ends <= 1'b0; failed <= 1'b0; grp <= '0;
    end else if (step) begin
      column <= column_next; rkind <= rkind_next; hacc <= hacc_next;
      nshift <= nshift_next; nnb <= nnb_next; tlen <= tlen_next;
      sign <= sign_next; first_line <= first_line_next; hdr <= hdr_next;
      ends <= ends_next; failed <= failed_next; grp <= grp_next;
    end
  end

endmodule

### rtl/orsp_fifo.sv
// ---------------------------------------------------------------------------
// orsp_fifo
// small result queue taking up to two results a cycle
// ---------------------------------------------------------------------------
module orsp_fifo import orsp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  result_t            push_a,
  input  result_t            push_b,
  output logic [FIFO_CW-1:0] count,
  output result_t            head,
  output logic               head_valid,
  input  logic               pop
);

  result_t            mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr, rptr;
  logic [FIFO_CW-1:0] n_push;
  logic               do_pop;

  assign n_push     = FIFO_CW'(push_a.valid) + FIFO_CW'(push_b.valid);
  assign head_valid = (count != '0);
  assign do_pop     = pop && head_valid;
  assign head       = mem[rptr];

  always_ff @(posedge clk) begin
    if (push_a.valid) mem[wptr] <= push_a;
    if (push_b.valid) mem[wptr + FIFO_AW'(1)] <= push_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      wptr <= wptr + n_push[FIFO_AW-1:0];
      if (do_pop) rptr <= rptr + FIFO_AW'(1);
      count <= count + n_push - FIFO_CW'(do_pop);
    end
  end

endmodule

### rtl/object_record_stream_parser_unit.sv
// ---------------------------------------------------------------------------
// object record stream parser unit
// checks and decodes H/T/D/R/M/E object records one character a cycle
// ---------------------------------------------------------------------------
// One character (or the end-of-file mark) is taken per clock. Each request is
// held in an input register, decoded combinationally against the running parser
// state, and its results go into a four-entry result queue; a character gives
// at most one result, end of file one or two. Input is taken as long as the
// queue has room for two more results, so with the output side draining the
// block runs at one request per cycle and each result is registered in the
// queue before it leaves. After the first format error a single invalid-format
// status is sent and characters are dropped until end of file, which always
// closes with the final load status and returns the parser to its reset state.
`include "object_record_stream_parser_unit_assert.svh"

module object_record_stream_parser_unit import orsp_pkg::*; (
  input logic      clk,
  input logic      rst,
  orsp_in_if.sink  in_item,
  orsp_out_if.source out_result
);

  // input register
  logic       ivld;
  logic       ikind;
  logic [7:0] ichar;

  // decode step and queue status
  logic               step;
  result_t            res_a, res_b;
  logic [FIFO_CW-1:0] qcount;
  result_t            head;
  logic               head_valid;

  // decode only when the queue can take the worst case of two results
  assign step = ivld && (qcount <= FIFO_CW'(FIFO_DEPTH - 2));
  assign in_item.ready = !ivld || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      ivld <= 1'b0;
    end else if (in_item.valid && in_item.ready) begin
      ivld <= 1'b1;
    end else if (step) begin
      ivld <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_item.valid && in_item.ready) begin
      ikind <= in_item.kind;
      ichar <= in_item.char_code;
    end
  end

  orsp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .kind      (ikind),
    .char_code (ichar),
    .res_a     (res_a),
    .res_b     (res_b)
  );

  orsp_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_a     (res_a),
    .push_b     (res_b),
    .count      (qcount),
    .head       (head),
    .head_valid (head_valid),
    .pop        (out_result.ready)
  );

  // output side straight off the queue head
  assign out_result.valid     = head_valid;
  assign out_result.field     = head.field;
  assign out_result.value     = head.value;
  assign out_result.symbol    = head.symbol;
  assign out_result.plus_sign = head.plus_sign;
  assign out_result.status    = head.status;
  assign out_result.last      = head.last;

  // results of one request are packed from the first slot
  `ORSP_ASSERT_NOW(a_pack, res_b.valid, res_a.valid && !res_a.last && res_b.last)
  // end of file always reports a status
  `ORSP_ASSERT_NOW(a_eof, step && ikind == KIND_EOF, res_a.valid)
  // queue never overfills
  `ORSP_ASSERT_NOW(a_room, 1'b1, qcount <= FIFO_CW'(FIFO_DEPTH))
  // an accepted request is held in the input register next cycle
  `ORSP_ASSERT_NEXT(a_hold, in_item.valid && in_item.ready, ivld)

endmodule

### verif/object_record_stream_parser_unit_tb.sv
// ---------------------------------------------------------------------------
// object record stream parser unit testbench
// feeds object-program text one character per request, predicts every
// decoded field with a local parser model and checks the result stream in
// order; directed files cover field extremes and each format error, then
// random files, mostly well formed with some corrupted, under random idling
// ---------------------------------------------------------------------------
module object_record_stream_parser_unit_tb;
  import orsp_pkg::*;

  // one expected decoded field
  typedef struct {
    field_t      f;
    logic [23:0] v;
    logic [47:0] s;
    bit          p;
    bit          st;
    bit          l;
  } field_rec_t;

  // one request for the input channel, with an optional typed-in result
  typedef struct {
    bit         k;
    logic [7:0] c;
    bit         typed;
    field_t     xf;
    bit         xs;
  } char_req_t;

  // one row of the directed table: a line of text, a newline, or end of file
  typedef struct {
    string  txt;
    bit     nl;
    bit     eof;
    bit     typed;
    field_t xf;
    bit     xs;
  } row_t;

  logic clk;
  logic rst;

  orsp_in_if  in_ch ();
  orsp_out_if out_ch ();

  object_record_stream_parser_unit dut (
    .clk        (clk),
    .rst        (rst),
    .in_item    (in_ch),
    .out_result (out_ch)
  );

  // stimulus and expectation stores
  char_req_t  char_q[$];
  row_t       rows[$];
  field_rec_t decoded_q[$];
  field_rec_t step_q[$];
  int         ptr;
  bit         took;
  int         errors;
  int         cyc;
  int         pause_at;

  // parser model state
  int unsigned col;
  rec_kind_t   rk;
  logic [23:0] acc;
  logic [47:0] nm;
  bit          nb;
  int unsigned tlen;
  bit          sgn;
  bit          first;
  bit          hdr;
  bit          endd;
  bit          bad;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cyc <= cyc + 1;

  // ---------------------------------------------------------------------
  // parser model
  // ---------------------------------------------------------------------

  // a request causes at most two results; each step keeps at most three
  task automatic put(field_t f, logic [23:0] v, logic [47:0] s, bit p, bit st);
    field_rec_t e;
    e = '{f, v, s, p, st, 1'b0};
    if (step_q.size() < 3) step_q.insert(step_q.size(), e);
  endtask

  // first format error: one invalid status, then characters are dropped until end of file
  task automatic flag_bad();
    bad = 1'b1;
    put(F_LOAD_STATUS, '0, '0, 1'b0, 1'b1);
  endtask

  task automatic clr_fields();
    acc = '0;
    nm  = '0;
    nb  = 1'b0;
  endtask

  task automatic clear_state();
    col   = 0;
    rk    = K_NONE;
    tlen  = 0;
    sgn   = 1'b0;
    first = 1'b1;
    hdr   = 1'b0;
    endd  = 1'b0;
    bad   = 1'b0;
    clr_fields();
  endtask

  // hex digit, either case; anything else is a format error
  task automatic hex_in(input logic [7:0] c, output bit ok);
    logic [3:0] d;
    ok = 1'b1;
    d  = '0;
    if (c >= "0" && c <= "9") d = 4'(c - "0");
    else if (c >= "A" && c <= "F") d = 4'(c - "A" + 10);
    else if (c >= "a" && c <= "f") d = 4'(c - "a" + 10);
    else ok = 1'b0;
    if (!ok) flag_bad();
    else acc = {acc[19:0], d};
  endtask

  // name character; a completed name that is all blanks is an error
  task automatic name_in(input logic [7:0] c, input bit complete, output bit ok);
    bit good;
    good = (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
           (c >= "a" && c <= "z") || c == " " || c == "-" || c == "_" || c == "+";
    ok = 1'b0;
    if (!good) begin
      flag_bad();
    end else begin
      nm = {nm[39:0], c};
      if (c != " ") nb = 1'b1;
      if (complete && !nb) flag_bad();
      else ok = 1'b1;
    end
  endtask

  // record letter at column zero, with the H-first and E-last order rules
  task automatic start_line(input logic [7:0] c);
    tlen = 0;
    sgn  = 1'b0;
    clr_fields();
    if (endd) begin
      flag_bad();
    end else if (c == "H") begin
      if (!first) flag_bad();
      else rk = K_H;
    end else if (first) begin
      flag_bad();
    end else begin
      case (c)
        "T": rk = K_T;
        "D": rk = K_D;
        "R": rk = K_R;
        "M": rk = K_M;
        "E": rk = K_E;
        default: flag_bad();
      endcase
    end
  endtask

  // record body at column p
  task automatic body_char(input logic [7:0] c, input int unsigned p);
    int unsigned q;
    bit ok;
    case (rk)
      K_H: begin
        if (p <= 6) begin
          name_in(c, p == 6, ok);
          if (ok && p == 6) begin
            put(F_PROG_NAME, '0, nm, 1'b0, 1'b0);
            clr_fields();
          end
        end else if (p <= 18) begin
          hex_in(c, ok);
          if (ok && (p == 12 || p == 18)) begin
            put(p == 12 ? F_START : F_SIZE, acc, '0, 1'b0, 1'b0);
            acc = '0;
          end
        end else begin
          flag_bad();
        end
      end
      K_T: begin
        if (p <= 6) begin
          hex_in(c, ok);
          if (ok && p == 6) begin
            put(F_TEXT_ADDR, acc, '0, 1'b0, 1'b0);
            acc = '0;
          end
        end else if (p <= 8) begin
          hex_in(c, ok);
          if (ok && p == 8) begin
            // byte count over the limit is an error at its second digit
            if (acc > MAX_TEXT_BYTES) begin
              flag_bad();
            end else begin
              tlen = acc;
              put(F_TEXT_LEN, acc, '0, 1'b0, 1'b0);
              acc = '0;
            end
          end
        end else if (p >= 9 + 2 * tlen) begin
          flag_bad();
        end else begin
          hex_in(c, ok);
          if (ok && ((p - 9) & 1)) begin
            put(F_TEXT_BYTE, acc, '0, 1'b0, 1'b0);
            acc = '0;
          end
        end
      end
      K_D: begin
        q = (p - 1) % 12;
        if (q < 6) begin
          name_in(c, q == 5, ok);
        end else begin
          hex_in(c, ok);
          if (ok && q == 11) begin
            put(F_EXPORT, acc, nm, 1'b0, 1'b0);
            clr_fields();
          end
        end
      end
      K_R: begin
        q = (p - 1) % 6;
        name_in(c, q == 5, ok);
        if (ok && q == 5) begin
          put(F_IMPORT, '0, nm, 1'b0, 1'b0);
          clr_fields();
        end
      end
      K_M: begin
        if (p <= 6) begin
          hex_in(c, ok);
          if (ok && p == 6) begin
            put(F_MOD_ADDR, acc, '0, 1'b0, 1'b0);
            acc = '0;
          end
        end else if (p <= 8) begin
          hex_in(c, ok);
          if (ok && p == 8) begin
            put(F_NIBBLES, acc, '0, 1'b0, 1'b0);
            acc = '0;
          end
        end else if (p == 9) begin
          if (c == "+") sgn = 1'b1;
          else if (c == "-") sgn = 1'b0;
          else flag_bad();
        end else if (p <= 15) begin
          name_in(c, p == 15, ok);
          if (ok && p == 15) begin
            put(F_MOD_SYMBOL, '0, nm, sgn, 1'b0);
            clr_fields();
          end
        end else begin
          flag_bad();
        end
      end
      K_E: begin
        if (p <= 6) begin
          hex_in(c, ok);
          if (ok && p == 6) begin
            put(F_ENTRY, acc, '0, 1'b0, 1'b0);
            acc = '0;
          end
        end else begin
          flag_bad();
        end
      end
      default: flag_bad();
    endcase
  endtask

  // newline: check the record length, then start over at column zero
  task automatic line_end();
    bit ok;
    case (rk)
      K_H: ok = (col == 19);
      K_T: ok = (col >= 9 && col == 9 + 2 * tlen);
      K_D: ok = (col >= 1 && (col - 1) % 12 == 0);
      K_R: ok = (col >= 1 && (col - 1) % 6 == 0);
      K_M: ok = (col == 9 || col == 16);
      K_E: ok = (col == 7);
      default: ok = 1'b0;
    endcase
    if (!ok) begin
      flag_bad();
    end else begin
      put(F_REC_END, '0, '0, 1'b0, 1'b0);
      if (rk == K_H) hdr = 1'b1;
      if (rk == K_E) endd = 1'b1;
      first = 1'b0;
    end
    col  = 0;
    rk   = K_NONE;
    tlen = 0;
    sgn  = 1'b0;
    clr_fields();
  endtask

  // work out the results of one accepted request and queue them
  task automatic decode_char(input char_req_t r);
    int af;
    int ast;
    step_q.delete();
    if (r.k == KIND_EOF) begin
      // a pending line without newline is closed first
      if (!bad && col > 0) line_end();
      put(F_LOAD_STATUS, '0, '0, 1'b0, bad || !hdr || !endd);
      clear_state();
    end else if (!bad) begin
      if (r.c == CH_NL) begin
        line_end();
      end else if (col >= MAX_LINE) begin
        flag_bad();
      end else begin
        if (col == 0) start_line(r.c);
        else body_char(r.c, col);
        if (!bad) col++;
      end
    end
    if (step_q.size() > 0) step_q[$].l = 1'b1;
    // typed-in rows must agree with the model on the closing result
    if (r.typed) begin
      af  = -1;
      ast = -1;
      if (step_q.size() > 0) begin
        af  = step_q[$].f;
        ast = step_q[$].st;
      end
      if (step_q.size() == 0 || step_q[$].f != r.xf || step_q[$].st != r.xs) begin
        errors++;
        $display("%0t typed result: expected field %0d status %0d actual field %0d status %0d",
                 $time, r.xf, r.xs, af, ast);
      end
    end
    foreach (step_q[i]) decoded_q.insert(decoded_q.size(), step_q[i]);
  endtask

  // ---------------------------------------------------------------------
  // stimulus builders
  // ---------------------------------------------------------------------

  task automatic push_req(bit k, logic [7:0] c, bit typed, field_t xf, bit xs);
    char_req_t r;
    r = '{k, c, typed, xf, xs};
    char_q.insert(char_q.size(), r);
  endtask

  task automatic add_row(string txt, bit nl, bit eof, bit typed, field_t xf, bit xs);
    row_t w;
    w = '{txt, nl, eof, typed, xf, xs};
    rows.insert(rows.size(), w);
  endtask

  function automatic logic [7:0] hex_ch(int unsigned d);
    if (d < 10) return 8'("0" + d);
    return 8'(($urandom_range(0, 1) ? "A" : "a") + d - 10);
  endfunction

  function automatic string hex_str(int unsigned v, int n);
    string s;
    s = "";
    for (int i = n - 1; i >= 0; i--) s = $sformatf("%s%c", s, hex_ch((v >> (4 * i)) & 15));
    return s;
  endfunction

  function automatic string rand_name();
    string set, s;
    set = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789 -_+";
    s = "";
    for (int i = 0; i < 6; i++) s = $sformatf("%s%c", s, set[$urandom_range(0, 65)]);
    if (s == "      ") s[$urandom_range(0, 5)] = "Q";
    return s;
  endfunction

  function automatic string rand_addr();
    return hex_str($urandom_range(0, 3) == 0 ? 24'hFFFFFF : $urandom(), 6);
  endfunction

  // one random T, D, R or M record body line
  function automatic string rand_line();
    string s;
    int n;
    case ($urandom_range(0, 3))
      0: begin
        n = ($urandom_range(0, 7) == 0) ? MAX_TEXT_BYTES : $urandom_range(0, 6);
        s = {"T", rand_addr(), hex_str(n, 2)};
        for (int i = 0; i < n; i++) s = {s, hex_str($urandom_range(0, 255), 2)};
      end
      1: begin
        s = "D";
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) s = {s, rand_name(), rand_addr()};
      end
      2: begin
        s = "R";
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) s = {s, rand_name()};
      end
      default: begin
        s = {"M", rand_addr(), hex_str($urandom_range(0, 255), 2)};
        if ($urandom_range(0, 1)) s = {s, $urandom_range(0, 1) ? "+" : "-", rand_name()};
      end
    endcase
    return s;
  endfunction

  // one random file: mostly well formed, some corrupted, some pure noise
  task automatic gen_file();
    string lines[$];
    string s;
    int pos;
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      for (int i = $urandom_range(3, 20); i > 0; i--)
        push_req(KIND_CHAR, 8'($urandom_range(0, 255)), 1'b0, F_PROG_NAME, 1'b0);
      push_req(KIND_EOF, 8'($urandom_range(0, 255)), 1'b0, F_PROG_NAME, 1'b0);
      return;
    end
    lines.insert(lines.size(), {"H", rand_name(), rand_addr(), rand_addr()});
    for (int i = $urandom_range(1, 4); i > 0; i--) lines.insert(lines.size(), rand_line());
    lines.insert(lines.size(), {"E", rand_addr()});
    if (sel <= 3) begin
      // corrupt one character, or cut or stretch a line
      pos = $urandom_range(0, lines.size() - 1);
      s = lines[pos];
      case ($urandom_range(0, 2))
        0: s[$urandom_range(0, s.len() - 1)] = 8'($urandom_range(0, 255));
        1: s = s.substr(0, s.len() - 2);
        default: s = {s, "0"};
      endcase
      lines[pos] = s;
    end
    foreach (lines[i]) begin
      s = lines[i];
      for (int j = 0; j < s.len(); j++) push_req(KIND_CHAR, s[j], 1'b0, F_PROG_NAME, 1'b0);
      // the final line sometimes ends at end of file without newline
      if (i != lines.size() - 1 || $urandom_range(0, 2) != 0)
        push_req(KIND_CHAR, CH_NL, 1'b0, F_PROG_NAME, 1'b0);
    end
    push_req(KIND_EOF, 8'($urandom_range(0, 255)), 1'b0, F_PROG_NAME, 1'b0);
  endtask

  // ---------------------------------------------------------------------
  // input side: accept at the rising edge, drive at the falling edge
  // ---------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) begin
      decode_char(char_q[ptr]);
      took = 1'b1;
    end
  end

  // output side: compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    field_rec_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (decoded_q.size() == 0) begin
        errors++;
        $display("%0t unexpected result: field %0d value %h", $time, out_ch.field,
                 out_ch.value);
      end else begin
        e = decoded_q.pop_front();
        if (out_ch.field != e.f) begin
          errors++;
          $display("%0t field: expected %0d actual %0d", $time, e.f, out_ch.field);
        end
        if (out_ch.value != e.v) begin
          errors++;
          $display("%0t value: expected %h actual %h", $time, e.v, out_ch.value);
        end
        if (out_ch.symbol != e.s) begin
          errors++;
          $display("%0t symbol: expected %h actual %h", $time, e.s, out_ch.symbol);
        end
        if (out_ch.plus_sign != e.p) begin
          errors++;
          $display("%0t plus_sign: expected %0d actual %0d", $time, e.p, out_ch.plus_sign);
        end
        if (out_ch.status != e.st) begin
          errors++;
          $display("%0t status: expected %0d actual %0d", $time, e.st, out_ch.status);
        end
        if (out_ch.last != e.l) begin
          errors++;
          $display("%0t last: expected %0d actual %0d", $time, e.l, out_ch.last);
        end
      end
    end
  end

  // receiver: random stalls, one long hold-off and one quiet stretch
  initial begin
    int hold;
    hold = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (cyc == 1500) hold = 400;
      if (hold > 0) begin
        hold--;
        out_ch.ready = 1'b0;
      end else if (cyc >= 600 && cyc < 1100) begin
        out_ch.ready = 1'b1;
      end else begin
        out_ch.ready = ($urandom_range(0, 99) >= 38);
      end
    end
  end

  // timeout
  initial begin
    #3000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // main sequence
  initial begin
    string longd;
    string s;
    bit pause_done;
    int n_rand;

    in_ch.valid     = 1'b0;
    in_ch.kind      = KIND_CHAR;
    in_ch.char_code = '0;
    rst    = 1'b1;
    ptr    = 0;
    took   = 1'b0;
    errors = 0;
    clear_state();

    // an export record that runs past the longest allowed line
    longd = "D";
    while (longd.len() < MAX_LINE + 1) longd = {longd, "SYM_01", "00ABCD"};
    longd = longd.substr(0, MAX_LINE);

    // directed table: text, newline, end of file, typed-in closing result
    add_row("", 0, 1, 1, F_LOAD_STATUS, 1);               // end of file with no header
    add_row("HPROG  000000FFFFFF", 1, 0, 1, F_REC_END, 0); // start and size extremes
    add_row("T00100003ABcdEf", 1, 0, 0, F_PROG_NAME, 0);
    s = "T0000001F";
    for (int i = 0; i < MAX_TEXT_BYTES; i++) s = {s, i[0] ? "ff" : "00"};
    add_row(s, 1, 0, 0, F_PROG_NAME, 0);                   // longest text record
    add_row("DEXP1  000000zz-_+9FFFFFF", 1, 0, 0, F_PROG_NAME, 0);
    add_row("RREF1  REF2  ", 1, 0, 0, F_PROG_NAME, 0);
    add_row("M00100005+REF1  ", 1, 0, 0, F_PROG_NAME, 0);
    add_row("M00300004-a     ", 1, 0, 0, F_PROG_NAME, 0);
    add_row("MFFFFFFFF", 1, 0, 0, F_PROG_NAME, 0);
    add_row("E000000", 1, 0, 1, F_REC_END, 0);
    add_row("", 0, 1, 1, F_LOAD_STATUS, 0);               // clean load
    add_row("HA     000000000010", 1, 0, 0, F_PROG_NAME, 0);
    add_row("T00000020", 0, 0, 1, F_LOAD_STATUS, 1);       // text count over the limit
    add_row("", 0, 1, 1, F_LOAD_STATUS, 1);
    add_row("H      ", 0, 1, 1, F_LOAD_STATUS, 1);         // all-blank name
    add_row("HB     000000000000", 1, 0, 0, F_PROG_NAME, 0);
    add_row("", 1, 1, 1, F_LOAD_STATUS, 1);               // empty line
    add_row($sformatf("HC     0000%c", 8'hC1), 0, 1, 1, F_LOAD_STATUS, 1); // non-ascii digit
    add_row("T", 0, 1, 1, F_LOAD_STATUS, 1);               // first line not a header
    add_row("HD     000000000000", 1, 0, 0, F_PROG_NAME, 0);
    add_row("H", 0, 1, 1, F_LOAD_STATUS, 1);               // second header
    add_row("HE     000000000000", 1, 0, 0, F_PROG_NAME, 0);
    add_row("E000000", 1, 0, 0, F_PROG_NAME, 0);
    add_row("R", 0, 1, 1, F_LOAD_STATUS, 1);               // line after the end record
    add_row("HF     000000000000", 1, 0, 0, F_PROG_NAME, 0);
    add_row("M00000001*", 0, 1, 1, F_LOAD_STATUS, 1);      // bad sign
    add_row("HG     000000000000", 1, 0, 0, F_PROG_NAME, 0);
    add_row("E0000001", 0, 1, 1, F_LOAD_STATUS, 1);        // record too long
    add_row("HH     000000000000", 1, 0, 0, F_PROG_NAME, 0);
    add_row(longd, 0, 1, 1, F_LOAD_STATUS, 1);             // over-long line
    add_row("HI     000000000000", 1, 0, 0, F_PROG_NAME, 0);
    add_row("E00abcd", 0, 1, 1, F_LOAD_STATUS, 0);         // last line ended by end of file
    add_row("HJ     000000000000", 1, 1, 1, F_LOAD_STATUS, 1); // no end record

    foreach (rows[i]) begin
      // typed result sits on the row's last request
      for (int j = 0; j < rows[i].txt.len(); j++)
        push_req(KIND_CHAR, rows[i].txt[j],
                 rows[i].typed && !rows[i].nl && !rows[i].eof && j == rows[i].txt.len() - 1,
                 rows[i].xf, rows[i].xs);
      if (rows[i].nl)
        push_req(KIND_CHAR, CH_NL, rows[i].typed && !rows[i].eof, rows[i].xf, rows[i].xs);
      if (rows[i].eof) push_req(KIND_EOF, 8'hFF, rows[i].typed, rows[i].xf, rows[i].xs);
    end
    pause_at = char_q.size();

    // random files until the item count is reached
    n_rand = char_q.size();
    while (char_q.size() - n_rand < 430) gen_file();

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    pause_done = 1'b0;
    forever begin
      @(negedge clk);
      if (took) begin
        took = 1'b0;
        ptr++;
        in_ch.valid = 1'b0;
      end
      if (ptr >= char_q.size()) break;
      if (in_ch.valid) continue;  // offered request still waiting
      if (ptr == pause_at && !pause_done) begin
        // sender waits for every expected result before the random part
        if (decoded_q.size() == 0) pause_done = 1'b1;
        continue;
      end
      if ((cyc >= 600 && cyc < 1100) || $urandom_range(0, 99) >= 38) begin
        in_ch.kind      = char_q[ptr].k;
        in_ch.char_code = char_q[ptr].c;
        in_ch.valid     = 1'b1;
      end
    end

    while (decoded_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (errors == 0 && decoded_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
